// ----- rtl/tpq_pkg.sv -----
package tpq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int PAYLOAD_BITS  = 32;

  // request codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // class codes, higher code wins
  localparam logic [1:0] CLS_LOW  = 2'd0;
  localparam logic [1:0] CLS_MID  = 2'd1;
  localparam logic [1:0] CLS_HIGH = 2'd2;

  typedef struct packed {
    logic                    req_type;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [1:0]              rank;
  } cmd_t;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic                    out_valid;
    logic [1:0]              status;
    logic                    is_empty;
  } res_t;

  // contents of one queue cell
  typedef struct packed {
    logic                    vld;
    logic [1:0]              cls;
    logic [PAYLOAD_BITS-1:0] payload;
  } cell_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

  function automatic logic [1:0] class_of_rank(input logic [1:0] rank);
    logic [1:0] cls;
    case (rank)
      2'd3:    cls = CLS_HIGH;
      2'd2:    cls = CLS_MID;
      default: cls = CLS_LOW;
    endcase
    return cls;
  endfunction

endpackage

// ----- rtl/three_class_priority_queue_core.sv -----
// Three-class strict priority queue. Items sit in a row of DEPTH cells kept
// sorted by class (high first) and, within a class, by arrival, so the head
// cell always holds the next item to leave. An enqueue is placed directly:
// every cell compares its class with the new item's in parallel and
// the cells behind the insertion point shift one place down the row; a
// dequeue shifts the whole row one place up. One request per cycle is
// accepted; the result waits in an output register and cmd_ready falls only
// while that register is held by a stalled consumer. A full queue rejects
// an enqueue with status 1, a dequeue on an empty queue returns status 2.
// No clearing pass after reset.
module three_class_priority_queue_core #(
  parameter int DEPTH = tpq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  tpq_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output tpq_pkg::res_t res
);
  import tpq_pkg::*;

  cell_t     cells [DEPTH];
  logic      ins   [DEPTH];
  cell_t     item;
  cell_ctl_t ctl;
  res_t      res_next;
  logic      accept;
  logic      full;
  logic      empty;

  assign cmd_ready = !res_valid || res_ready;
  assign accept    = cmd_valid && cmd_ready;
  assign full      = cells[DEPTH-1].vld;
  assign empty     = !cells[0].vld;

  assign item.vld     = 1'b1;
  assign item.cls     = class_of_rank(cmd.rank);
  assign item.payload = cmd.payload;

  assign ctl.enq = accept && (cmd.req_type == REQ_ENQ) && !full;
  assign ctl.deq = accept && (cmd.req_type == REQ_DEQ) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_t left_c;
    logic  left_i;
    cell_t right_c;

    if (i == 0) begin : g_first
      assign left_c = '0;
      assign left_i = 1'b0;
    end else begin : g_mid
      assign left_c = cells[i-1];
      assign left_i = ins[i-1];
    end

    if (i == DEPTH-1) begin : g_last
      assign right_c = '0;
    end else begin : g_inner
      assign right_c = cells[i+1];
    end

    tpq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .item     (item),
      .left     (left_c),
      .left_ins (left_i),
      .right    (right_c),
      .q        (cells[i]),
      .ins      (ins[i])
    );
  end

  always_comb begin
    res_next = '0;
    if (cmd.req_type == REQ_ENQ) begin
      res_next.status   = full ? ST_FULL : ST_OK;
      res_next.is_empty = 1'b0;
    end else if (empty) begin
      res_next.status   = ST_EMPTY;
      res_next.is_empty = 1'b1;
    end else begin
      res_next.out_payload = cells[0].payload;
      res_next.out_valid   = 1'b1;
      res_next.status      = ST_OK;
      res_next.is_empty    = !cells[1].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (accept) begin
      res <= res_next;
    end
  end

  // an empty head implies an empty last cell
  a_contig: assert property (@(posedge clk) disable iff (rst)
    !cells[0].vld |-> !cells[DEPTH-1].vld)
    else $error("occupied cells not contiguous");

  // head and next cell stay in class order
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    cells[1].vld |-> (cells[0].vld && cells[0].cls >= cells[1].cls))
    else $error("cell row out of class order");

  // an accepted enqueue always leaves the head occupied
  a_enq_head: assert property (@(posedge clk) disable iff (rst)
    ctl.enq |=> cells[0].vld)
    else $error("head empty after enqueue");

  // a returned item always carries an ok status
  a_res_ok: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.out_valid) |-> (res.status == ST_OK && res.out_valid == 1'b1))
    else $error("returned item with error status");

endmodule

// ----- rtl/tpq_cell.sv -----
module tpq_cell (
  input  logic              clk,
  input  logic              rst,
  input  tpq_pkg::cell_ctl_t ctl,
  input  tpq_pkg::cell_t    item,
  input  tpq_pkg::cell_t    left,
  input  logic              left_ins,
  input  tpq_pkg::cell_t    right,
  output tpq_pkg::cell_t    q,
  output logic              ins
);
  import tpq_pkg::*;

  // new item belongs ahead of this cell: empty slot or strictly lower class
  assign ins = !q.vld || (q.cls < item.cls);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (ctl.deq) begin
      q <= right;
    end else if (ctl.enq && ins) begin
      q <= left_ins ? left : item;
    end
  end

endmodule
